/* rtl/pwe_pkg.sv */
// Shared types, codes, constants and elaboration-time table functions for the waveform evaluator.
package pwe_pkg;

  localparam int WORD_W               = 32;
  localparam int WORK_BITS            = 30;
  localparam int CORDIC_W             = 34;
  localparam int RED_W                = 65;
  localparam int CFG_INDEX_W          = 3;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int FRAC_BITS_DEF        = 16;

  localparam logic [1:0] MODE_CONST  = 2'd0;
  localparam logic [1:0] MODE_SINE   = 2'd1;
  localparam logic [1:0] MODE_LINEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_A    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_B    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_C    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_D    = 3'd4;

  // 2*pi and pi/4 scaled by 2^60 and 2^62
  localparam logic [63:0] TWO_PI_Q60     = 64'h6487ED5110B4611A;
  localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic [1:0]               wave_mode;
    logic signed [WORD_W-1:0] coef_a;
    logic signed [WORD_W-1:0] coef_b;
    logic signed [WORD_W-1:0] coef_c;
    logic signed [WORD_W-1:0] coef_d;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic signed [WORD_W-1:0] time_value;
  } tag_t;

  function automatic logic [63:0] const_q(input logic [63:0] c, input int s);
    return (c + (64'd1 << (s - 1))) >> s;
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bt;
    logic [63:0] v;
    v   = x;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] cordic_gain(input int iters);
    logic [63:0] k2;
    k2 = 64'd1 << 60;
    for (int i = 0; i < 32; i++) begin
      if (i < iters) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
    end
    return isqrt64(k2);
  endfunction

  // arctan(2^-i) in Q30 from a Q62 series sum
  function automatic logic signed [63:0] atan_q30(input int i);
    logic signed [63:0] acc;
    logic [63:0]        term;
    acc = '0;
    if (i == 0) return $signed(const_q(QUARTER_PI_Q62, 32));
    for (int n = 1; n <= 61; n += 2) begin
      if (n * i <= 62) begin
        term = udiv64(64'd1 << (62 - n * i), 64'(n));
        if ((((n - 1) >> 1) & 1) != 0) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
    end
    return (acc + (64'sd1 <<< 31)) >>> 32;
  endfunction

  // smallest s with tp << s >= 2^63
  function automatic int red_shift(input logic [63:0] tp);
    int s;
    s = 0;
    for (int j = 0; j < 64; j++) begin
      if ((65'(tp) << s) < (65'd1 << 63)) s = s + 1;
    end
    return s;
  endfunction

endpackage

/* rtl/pwe_phase.sv */
// Phase pipeline: b*t+c, modulo 2*pi reduction, fold to [-pi/2, pi/2], scale to Q30.
module pwe_phase #(
  parameter int FRAC_BITS = pwe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  pwe_pkg::cfg_t                       cfg,
  input  logic                                sample_valid,
  input  logic signed [pwe_pkg::WORD_W-1:0]   time_value,
  output pwe_pkg::tag_t                       tag_out,
  output logic signed [pwe_pkg::CORDIC_W-1:0] z_out
);

  localparam int CW    = pwe_pkg::CORDIC_W;
  localparam int RW    = pwe_pkg::RED_W;
  localparam int F2    = 2 * FRAC_BITS;
  localparam int RSW   = F2 + 4;
  localparam int WIDEW = 66;

  localparam logic [63:0] TP = pwe_pkg::const_q(pwe_pkg::TWO_PI_Q60, 60 - F2);
  localparam logic [63:0] PI = pwe_pkg::const_q(pwe_pkg::TWO_PI_Q60, 61 - F2);
  localparam logic [63:0] HP = pwe_pkg::const_q(pwe_pkg::TWO_PI_Q60, 62 - F2);
  localparam int S  = pwe_pkg::red_shift(TP);
  localparam int NR = S + 1;
  localparam logic [RW-1:0] OFFSET = RW'(TP) << S;

  localparam logic signed [RSW-1:0] TP_S     = RSW'(TP);
  localparam logic signed [RSW-1:0] PI_S     = RSW'(PI);
  localparam logic signed [RSW-1:0] HP_S     = RSW'(HP);
  localparam logic signed [RSW-1:0] NEG_PI_S = -PI_S;
  localparam logic signed [RSW-1:0] NEG_HP_S = -HP_S;

  pwe_pkg::tag_t             a_tag;
  logic signed [63:0]        a_prod;
  pwe_pkg::tag_t             red_tag [NR+1];
  logic [RW-1:0]             red_v   [NR+1];
  logic signed [RSW-1:0]     red_r;
  pwe_pkg::tag_t             f1_tag;
  logic signed [RSW-1:0]     f1_r;
  pwe_pkg::tag_t             f2_tag;
  logic signed [RSW-1:0]     f2_r;
  logic signed [RSW-1:0]     f2_r_next;
  logic signed [CW-1:0]      z_next;
  logic signed [WIDEW-1:0]   c_wide;

  assign c_wide = WIDEW'(cfg.coef_c) <<< FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag.valid      <= 1'b0;
      red_tag[0].valid <= 1'b0;
    end else if (advance) begin
      a_tag.valid      <= sample_valid;
      a_tag.time_value <= time_value;
      a_prod           <= $signed(cfg.coef_b) * $signed(time_value);
      red_tag[0]       <= a_tag;
      red_v[0]         <= RW'(WIDEW'(a_prod) + c_wide + WIDEW'(OFFSET));
    end
  end

  for (genvar g = 0; g < NR; g++) begin : g_red
    localparam int K = S - g;
    localparam logic [RW-1:0] CMP = RW'(TP) << K;
    always_ff @(posedge clk) begin
      if (rst) begin
        red_tag[g+1].valid <= 1'b0;
      end else if (advance) begin
        red_tag[g+1] <= red_tag[g];
        red_v[g+1]   <= (red_v[g] >= CMP) ? red_v[g] - CMP : red_v[g];
      end
    end
  end

  assign red_r = red_v[NR][RSW-1:0];

  always_comb begin
    if (f1_r > HP_S) f2_r_next = PI_S - f1_r;
    else if (f1_r < NEG_HP_S) f2_r_next = NEG_PI_S - f1_r;
    else f2_r_next = f1_r;
  end

  if (F2 > pwe_pkg::WORK_BITS) begin : g_round
    localparam int ZSH = F2 - pwe_pkg::WORK_BITS;
    localparam logic signed [WIDEW-1:0] HALF = WIDEW'(1) <<< (ZSH - 1);
    assign z_next = CW'((WIDEW'(f2_r) + HALF) >>> ZSH);
  end else begin : g_scale
    assign z_next = CW'(WIDEW'(f2_r) <<< (pwe_pkg::WORK_BITS - F2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_tag.valid  <= 1'b0;
      f2_tag.valid  <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (advance) begin
      f1_tag  <= red_tag[NR];
      f1_r    <= (red_r > PI_S) ? red_r - TP_S : red_r;
      f2_tag  <= f1_tag;
      f2_r    <= f2_r_next;
      tag_out <= f2_tag;
      z_out   <= z_next;
    end
  end

endmodule

/* rtl/pwe_cordic.sv */
// Unrolled rotation-mode CORDIC, one iteration per register stage, sine out in Q30.
module pwe_cordic #(
  parameter int CORDIC_ITERATIONS = pwe_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  pwe_pkg::tag_t                       tag_in,
  input  logic signed [pwe_pkg::CORDIC_W-1:0] z_in,
  output pwe_pkg::tag_t                       tag_out,
  output logic signed [pwe_pkg::CORDIC_W-1:0] y_out
);

  localparam int CW = pwe_pkg::CORDIC_W;
  localparam int N  = CORDIC_ITERATIONS;
  localparam logic signed [CW-1:0] GAIN = CW'(pwe_pkg::cordic_gain(N));

  pwe_pkg::tag_t        tag [1:N];
  logic signed [CW-1:0] x   [1:N];
  logic signed [CW-1:0] y   [1:N];
  logic signed [CW-1:0] z   [1:N];

  for (genvar g = 0; g < N; g++) begin : g_iter
    localparam logic signed [CW-1:0] AT = CW'(pwe_pkg::atan_q30(g));
    pwe_pkg::tag_t        tag_cur;
    logic signed [CW-1:0] x_cur;
    logic signed [CW-1:0] y_cur;
    logic signed [CW-1:0] z_cur;

    if (g == 0) begin : g_head
      assign tag_cur = tag_in;
      assign x_cur   = GAIN;
      assign y_cur   = '0;
      assign z_cur   = z_in;
    end else begin : g_body
      assign tag_cur = tag[g];
      assign x_cur   = x[g];
      assign y_cur   = y[g];
      assign z_cur   = z[g];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[g+1].valid <= 1'b0;
      end else if (advance) begin
        tag[g+1] <= tag_cur;
        if (z_cur >= 0) begin
          x[g+1] <= x_cur - (y_cur >>> g);
          y[g+1] <= y_cur + (x_cur >>> g);
          z[g+1] <= z_cur - AT;
        end else begin
          x[g+1] <= x_cur + (y_cur >>> g);
          y[g+1] <= y_cur - (x_cur >>> g);
          z[g+1] <= z_cur + AT;
        end
      end
    end
  end

  assign tag_out = tag[N];
  assign y_out   = y[N];

endmodule

/* rtl/pwe_post.sv */
// Output pipeline: shared multiply, rounding, offset add, saturation and mode select.
module pwe_post #(
  parameter int FRAC_BITS = pwe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  pwe_pkg::cfg_t                       cfg,
  input  pwe_pkg::tag_t                       tag_in,
  input  logic signed [pwe_pkg::CORDIC_W-1:0] y_in,
  output logic                                out_valid,
  output logic signed [pwe_pkg::WORD_W-1:0]   out_value,
  output logic                                out_sat
);

  localparam int W     = pwe_pkg::WORD_W;
  localparam int CW    = pwe_pkg::CORDIC_W;
  localparam int PW    = W + CW;
  localparam int RND_W = 2 * W - FRAC_BITS;
  localparam int SUM_W = RND_W + 1;
  localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_W = PW'(1) <<< (pwe_pkg::WORK_BITS - 1);

  logic                     linear;
  logic signed [CW-1:0]     op;
  logic                     m1_valid;
  logic signed [PW-1:0]     m1_prod;
  logic                     m2_valid;
  logic signed [RND_W-1:0]  m2_rnd;
  logic signed [RND_W-1:0]  rnd_next;
  logic signed [W-1:0]      addend;
  logic signed [SUM_W-1:0]  sum;
  logic [SUM_W-W:0]         hi;
  logic signed [W-1:0]      value_next;
  logic                     sat_next;

  assign linear = (cfg.wave_mode == pwe_pkg::MODE_LINEAR);
  assign op     = linear ? CW'(tag_in.time_value) : y_in;

  assign rnd_next = linear ? RND_W'((m1_prod + HALF_F) >>> FRAC_BITS)
                           : RND_W'((m1_prod + HALF_W) >>> pwe_pkg::WORK_BITS);

  assign addend = linear ? cfg.coef_b : cfg.coef_d;
  assign sum    = SUM_W'(m2_rnd) + SUM_W'(addend);
  assign hi     = sum[SUM_W-1:W-1];

  always_comb begin
    value_next = '0;
    sat_next   = 1'b0;
    case (cfg.wave_mode)
      pwe_pkg::MODE_CONST: begin
        value_next = cfg.coef_a;
      end
      pwe_pkg::MODE_SINE, pwe_pkg::MODE_LINEAR: begin
        if (!sum[SUM_W-1] && (|hi)) begin
          value_next = {1'b0, {(W-1){1'b1}}};
          sat_next   = 1'b1;
        end else if (sum[SUM_W-1] && !(&hi)) begin
          value_next = {1'b1, {(W-1){1'b0}}};
          sat_next   = 1'b1;
        end else begin
          value_next = sum[W-1:0];
        end
      end
      default: begin
        value_next = '0;
        sat_next   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      m1_valid  <= tag_in.valid;
      m1_prod   <= $signed(cfg.coef_a) * op;
      m2_valid  <= m1_valid;
      m2_rnd    <= rnd_next;
      out_valid <= m2_valid;
      out_value <= value_next;
      out_sat   <= sat_next;
    end
  end

endmodule

/* rtl/parametric_waveform_evaluator_unit.sv */
// Top level: configuration registers, phase/CORDIC/output pipelines and output skid stage.
//
// Takes one time sample per cycle while sample_stall is low and returns one Q16.16 waveform
// value per sample, in order. The result path runs through the modulo-2*pi reduction chain
// (one compare-subtract stage per quotient bit of the 65-bit phase), one stage per CORDIC
// iteration and the output multiply, round and saturate stages. A stalled result backs up
// into a one-beat skid register, so the stall toward the sample side is registered and the
// pipeline still accepts a sample in the cycle in which the output stalls. Write configuration
// only while no samples are in flight; cfg_ready is always high.
module parametric_waveform_evaluator_unit #(
  parameter int CORDIC_ITERATIONS = pwe_pkg::CORDIC_ITERATIONS_DEF,
  parameter int FRAC_BITS         = pwe_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pwe_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pwe_pkg::WORD_W-1:0]           cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [pwe_pkg::WORD_W-1:0]    time_value,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [pwe_pkg::WORD_W-1:0]    wave_value,
  output logic                                 saturated
);

  pwe_pkg::cfg_t                       cfg;
  logic                                advance;
  pwe_pkg::tag_t                       phase_tag;
  logic signed [pwe_pkg::CORDIC_W-1:0] phase_z;
  pwe_pkg::tag_t                       cordic_tag;
  logic signed [pwe_pkg::CORDIC_W-1:0] cordic_y;
  logic                                post_valid;
  logic signed [pwe_pkg::WORD_W-1:0]   post_value;
  logic                                post_sat;
  logic                                skid_valid;
  logic signed [pwe_pkg::WORD_W-1:0]   skid_value;
  logic                                skid_sat;

  assign cfg_ready    = 1'b1;
  assign advance      = !skid_valid;
  assign sample_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwe_pkg::REG_WAVE_MODE: cfg.wave_mode <= cfg_data[1:0];
        pwe_pkg::REG_COEF_A:    cfg.coef_a    <= cfg_data;
        pwe_pkg::REG_COEF_B:    cfg.coef_b    <= cfg_data;
        pwe_pkg::REG_COEF_C:    cfg.coef_c    <= cfg_data;
        pwe_pkg::REG_COEF_D:    cfg.coef_d    <= cfg_data;
        default: ;
      endcase
    end
  end

  pwe_phase #(
    .FRAC_BITS(FRAC_BITS)
  ) u_phase (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .cfg(cfg),
    .sample_valid(sample_valid),
    .time_value(time_value),
    .tag_out(phase_tag),
    .z_out(phase_z)
  );

  pwe_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .tag_in(phase_tag),
    .z_in(phase_z),
    .tag_out(cordic_tag),
    .y_out(cordic_y)
  );

  pwe_post #(
    .FRAC_BITS(FRAC_BITS)
  ) u_post (
    .clk(clk),
    .rst(rst),
    .advance(advance),
    .cfg(cfg),
    .tag_in(cordic_tag),
    .y_in(cordic_y),
    .out_valid(post_valid),
    .out_value(post_value),
    .out_sat(post_sat)
  );

  // output register plus skid; pipeline advances while skid is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        wave_value   <= skid_value;
        saturated    <= skid_sat;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= post_valid;
        wave_value   <= post_value;
        saturated    <= post_sat;
      end
    end else if (!skid_valid && post_valid) begin
      skid_valid <= 1'b1;
      skid_value <= post_value;
      skid_sat   <= post_sat;
    end
  end

endmodule
